[sv/qcpv_pkg.sv]
// ----------------------------------------------------------------------------
// qcpv_pkg
// shared types and constants for quad projection and culling
// ----------------------------------------------------------------------------
package qcpv_pkg;

  localparam int unsigned NVERT = 4;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NEAR   = 3'd0,
    REG_FAR    = 3'd1,
    REG_FOCAL  = 3'd2,
    REG_VIEW_W = 3'd3,
    REG_VIEW_H = 3'd4,
    REG_SCR_W  = 3'd5,
    REG_SCR_H  = 3'd6,
    REG_CULL   = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    CULL_NONE = 2'd0,
    CULL_CW   = 2'd1,
    CULL_CCW  = 2'd2,
    CULL_RSVD = 2'd3
  } cull_mode_e;

  typedef struct packed {
    logic signed [31:0] near_plane;
    logic signed [31:0] far_plane;
    logic [30:0]        focal_distance;
    logic [30:0]        view_width;
    logic [30:0]        view_height;
    logic [12:0]        screen_width;
    logic [12:0]        screen_height;
    cull_mode_e         cull_mode;
  } cfg_t;

endpackage

[sv/qcpv_if.sv]
// ----------------------------------------------------------------------------
// qcpv_if
// valid/ready channel carrying a generic payload
// ----------------------------------------------------------------------------
interface qcpv_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[sv/qcpv_cfg.sv]
// ----------------------------------------------------------------------------
// qcpv_cfg
// configuration register file
// ----------------------------------------------------------------------------
module qcpv_cfg (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [qcpv_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [qcpv_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  output qcpv_pkg::cfg_t                       cfg_o
);
  qcpv_pkg::cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.near_plane     <= 32'sd65536;
      cfg_q.far_plane      <= 32'sd65536000;
      cfg_q.focal_distance <= 31'd65536;
      cfg_q.view_width     <= 31'd131072;
      cfg_q.view_height    <= 31'd131072;
      cfg_q.screen_width   <= 13'd480;
      cfg_q.screen_height  <= 13'd480;
      cfg_q.cull_mode      <= qcpv_pkg::CULL_CCW;
    end else if (cfg_valid_i) begin
      unique case (qcpv_pkg::reg_idx_e'(cfg_index_i))
        qcpv_pkg::REG_NEAR:   cfg_q.near_plane     <= cfg_data_i;
        qcpv_pkg::REG_FAR:    cfg_q.far_plane      <= cfg_data_i;
        qcpv_pkg::REG_FOCAL:  cfg_q.focal_distance <= cfg_data_i[30:0];
        qcpv_pkg::REG_VIEW_W: cfg_q.view_width     <= cfg_data_i[30:0];
        qcpv_pkg::REG_VIEW_H: cfg_q.view_height    <= cfg_data_i[30:0];
        qcpv_pkg::REG_SCR_W:  cfg_q.screen_width   <= cfg_data_i[12:0];
        qcpv_pkg::REG_SCR_H:  cfg_q.screen_height  <= cfg_data_i[12:0];
        qcpv_pkg::REG_CULL:   cfg_q.cull_mode      <= qcpv_pkg::cull_mode_e'(cfg_data_i[1:0]);
        default: ;
      endcase
    end
  end
endmodule

[sv/qcpv_div.sv]
// ----------------------------------------------------------------------------
// qcpv_div
// pipelined restoring divider, one quotient bit per stage, unsigned magnitudes
// ----------------------------------------------------------------------------
module qcpv_div #(
  parameter int unsigned NW = 80,
  parameter int unsigned DW = 48,
  parameter int unsigned TW = 8
) (
  input  logic          clk_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [TW-1:0] tag_i,
  input  logic          en_i,
  output logic [NW-1:0] quo_o,
  output logic [TW-1:0] tag_o
);
  logic [NW-1:0] num_q [1:NW];
  logic [DW:0]   rem_q [1:NW];
  logic [DW-1:0] den_q [1:NW];
  logic [TW-1:0] tag_q [1:NW];

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic [NW-1:0] num_s;
    logic [DW:0]   rem_s;
    logic [DW-1:0] den_s;
    logic [TW-1:0] tag_s;
    logic [DW+1:0] sh_d;
    logic [DW+1:0] df_d;
    if (s == 0) begin : g_first
      assign num_s = num_i;
      assign rem_s = '0;
      assign den_s = den_i;
      assign tag_s = tag_i;
    end else begin : g_next
      assign num_s = num_q[s];
      assign rem_s = rem_q[s];
      assign den_s = den_q[s];
      assign tag_s = tag_q[s];
    end
    always_comb begin
      sh_d = {rem_s, num_s[NW-1]};
      df_d = sh_d - {2'b00, den_s};
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!df_d[DW+1]) begin
          rem_q[s+1] <= df_d[DW:0];
          num_q[s+1] <= {num_s[NW-2:0], 1'b1};
        end else begin
          rem_q[s+1] <= sh_d[DW:0];
          num_q[s+1] <= {num_s[NW-2:0], 1'b0};
        end
        den_q[s+1] <= den_s;
        tag_q[s+1] <= tag_s;
      end
    end
  end

  assign quo_o = num_q[NW];
  assign tag_o = tag_q[NW];
endmodule

[sv/qcpv_top_core.sv]
// ----------------------------------------------------------------------------
// qcpv_core
// projection, screen map, depth/view test and back-face pipeline
// ----------------------------------------------------------------------------
module qcpv_core #(
  parameter int unsigned CW = 32,
  parameter int unsigned FB = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                in_valid_i,
  input  logic signed [CW-1:0] vx_i [4],
  input  logic signed [CW-1:0] vy_i [4],
  input  logic signed [CW-1:0] vz_i [4],
  input  qcpv_pkg::cfg_t      cfg_i,
  output logic                out_valid_o,
  output logic signed [CW-1:0] sx_o [4],
  output logic signed [CW-1:0] sy_o [4],
  output logic                clipped_o,
  output logic                back_o
);
  localparam int unsigned NW  = CW + 31;    // |focal * c|
  localparam int unsigned EW  = CW + 1;     // edge
  localparam int unsigned PW  = 2 * EW;     // edge product
  localparam int unsigned NRW = PW + 1;     // normal component
  localparam int unsigned LB  = CW + 2;     // low slice of a normal component
  localparam int unsigned DTW = NRW + CW;   // normal * coord
  localparam int unsigned DSW = DTW + 2;    // dot sum
  localparam int unsigned LAT = NW + 5;
  localparam int unsigned SMW = CW + 16;    // (W-1)*(ONE+p)
  localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

  // stage 0: products for projection and edges
  logic [LAT-1:0] vld_q;
  logic signed [NW:0]   n_q [8];
  logic signed [CW-1:0] z_q [4];
  logic                 dclip_q;
  logic signed [EW-1:0] e1_q [3], e2_q [3];
  logic signed [CW-1:0] v_q [4][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (en_i) vld_q <= {vld_q[LAT-2:0], in_valid_i};
  end

  logic dclip_d;
  always_comb begin
    logic any_near, all_far;
    any_near = 1'b0;
    all_far  = 1'b1;
    for (int i = 0; i < 4; i++) begin
      if ($signed(vz_i[i]) <= $signed(cfg_i.near_plane)) any_near = 1'b1;
      if ($signed(vz_i[i]) <= $signed(cfg_i.far_plane)) all_far = 1'b0;
    end
    dclip_d = any_near | all_far;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 4; i++) begin
        n_q[2*i]   <= $signed({1'b0, cfg_i.focal_distance}) * vx_i[i];
        n_q[2*i+1] <= $signed({1'b0, cfg_i.focal_distance}) * vy_i[i];
        z_q[i]     <= vz_i[i];
        v_q[i][0]  <= vx_i[i];
        v_q[i][1]  <= vy_i[i];
        v_q[i][2]  <= vz_i[i];
      end
      e1_q[0] <= EW'(vx_i[1]) - EW'(vx_i[0]);
      e1_q[1] <= EW'(vy_i[1]) - EW'(vy_i[0]);
      e1_q[2] <= EW'(vz_i[1]) - EW'(vz_i[0]);
      e2_q[0] <= EW'(vx_i[2]) - EW'(vx_i[1]);
      e2_q[1] <= EW'(vy_i[2]) - EW'(vy_i[1]);
      e2_q[2] <= EW'(vz_i[2]) - EW'(vz_i[1]);
      dclip_q <= dclip_d;
    end
  end

  // stage 1: magnitudes into dividers; cross products
  logic [NW-1:0] mag_q [8];
  logic [CW-1:0] zm_q [8];
  logic [2:0]    sg_q [8];  // {zero z, result negative, numerator zero}
  logic signed [PW-1:0] cp_q [6];
  logic signed [CW-1:0] v1_q [4][3];
  logic dclip1_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < 8; j++) begin
        mag_q[j] <= n_q[j][NW] ? NW'(-n_q[j]) : n_q[j][NW-1:0];
        zm_q[j]  <= z_q[j/2][CW-1] ? CW'(-z_q[j/2]) : z_q[j/2];
        sg_q[j]  <= {z_q[j/2] == '0, n_q[j][NW] ^ z_q[j/2][CW-1], n_q[j] == '0};
      end
      cp_q[0] <= e1_q[1] * e2_q[2];
      cp_q[1] <= e1_q[2] * e2_q[1];
      cp_q[2] <= e1_q[2] * e2_q[0];
      cp_q[3] <= e1_q[0] * e2_q[2];
      cp_q[4] <= e1_q[0] * e2_q[1];
      cp_q[5] <= e1_q[1] * e2_q[0];
      v1_q     <= v_q;
      dclip1_q <= dclip_q;
    end
  end

  logic [NW-1:0] quo [8];
  logic [2:0]    sgo [8];
  for (genvar j = 0; j < 8; j++) begin : g_div
    qcpv_div #(.NW(NW), .DW(CW), .TW(3)) u_div (
      .clk_i, .num_i(mag_q[j]), .den_i(zm_q[j]), .tag_i(sg_q[j]), .en_i,
      .quo_o(quo[j]), .tag_o(sgo[j])
    );
  end

  // back-face: normal, then split dot products, then dots, then decision, then delay
  logic signed [NRW-1:0] nr_q [3];
  logic signed [CW-1:0]  v2_q [4][3];
  logic signed [LB+CW:0] dl_q [4][3];
  logic signed [2*CW:0]  dh_q [4][3];
  logic signed [DTW-1:0] dt_q [4][3];
  logic bk_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nr_q[0] <= NRW'(cp_q[0]) - NRW'(cp_q[1]);
      nr_q[1] <= NRW'(cp_q[2]) - NRW'(cp_q[3]);
      nr_q[2] <= NRW'(cp_q[4]) - NRW'(cp_q[5]);
      v2_q <= v1_q;
      for (int i = 0; i < 4; i++)
        for (int k = 0; k < 3; k++) begin
          dl_q[i][k] <= $signed({1'b0, nr_q[k][LB-1:0]}) * v2_q[i][k];
          dh_q[i][k] <= $signed(nr_q[k][NRW-1:LB]) * v2_q[i][k];
          dt_q[i][k] <= (DTW'(dh_q[i][k]) <<< LB) + DTW'(dl_q[i][k]);
        end
    end
  end
  logic bk_d;
  always_comb begin
    logic signed [DSW-1:0] d;
    logic all_pos, all_np;
    all_pos = 1'b1;
    all_np  = 1'b1;
    for (int i = 0; i < 4; i++) begin
      d = DSW'(dt_q[i][0]) + DSW'(dt_q[i][1]) + DSW'(dt_q[i][2]);
      if (d > 0) all_np = 1'b0;
      else all_pos = 1'b0;
    end
    case (cfg_i.cull_mode)
      qcpv_pkg::CULL_CW:  bk_d = all_np;
      qcpv_pkg::CULL_CCW: bk_d = all_pos;
      default:            bk_d = 1'b0;
    endcase
  end
  always_ff @(posedge clk_i) if (en_i) bk_q <= bk_d;

  // align back flag and depth clip with divider output
  logic [NW-1:0] bkd_q, dcd_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bkd_q <= {bkd_q[NW-2:0], bk_q};
      dcd_q <= {dcd_q[NW-2:0], dclip1_q};
    end
  end
  // bk_q trails stage 1 by nr_q, dl_q/dh_q, dt_q and bk_q, the divider by its stages: NW-4 delay taps
  logic bk_al, dc_al;
  assign bk_al = bkd_q[NW-5];
  assign dc_al = dcd_q[NW-1];

  // stage d+1: saturate quotient
  logic signed [CW-1:0] p_q [8];
  logic bk2_q, dc2_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < 8; j++) begin
        if (sgo[j][2])
          p_q[j] <= sgo[j][0] ? '0 : (sgo[j][1] ? CMIN : CMAX);
        else if (sgo[j][1])
          p_q[j] <= (quo[j] > NW'({1'b1, {(CW-1){1'b0}}})) ? CMIN : -CW'(quo[j]);
        else
          p_q[j] <= (quo[j] > NW'(CMAX)) ? CMAX : CW'(quo[j]);
      end
      bk2_q <= bk_al;
      dc2_q <= dc_al;
    end
  end

  // stage d+2: screen multiply and view test
  logic signed [SMW-1:0] sm_q [8];
  logic vclip_q, bk3_q, dc3_q;
  logic vclip_d;
  always_comb begin
    logic [3:0] t;
    t = 4'b1111;
    for (int i = 0; i < 3; i++) begin
      if (!($signed({p_q[2*i+1], 1'b0}) > $signed({2'b00, cfg_i.view_height})))  t[0] = 1'b0;
      if (!($signed({p_q[2*i+1], 1'b0}) < -$signed({2'b00, cfg_i.view_height}))) t[1] = 1'b0;
      if (!($signed({p_q[2*i], 1'b0}) < -$signed({2'b00, cfg_i.view_width})))    t[2] = 1'b0;
      if (!($signed({p_q[2*i], 1'b0}) > $signed({2'b00, cfg_i.view_width})))     t[3] = 1'b0;
    end
    vclip_d = |t;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 4; i++) begin
        sm_q[2*i] <= ($signed({1'b0, cfg_i.screen_width}) - 14'sd1)
                     * ($signed((CW+1)'(p_q[2*i])) + (CW+1)'(1 << FB));
        sm_q[2*i+1] <= ($signed({1'b0, cfg_i.screen_height}) - 14'sd1)
                       * ($signed((CW+1)'(p_q[2*i+1])) + (CW+1)'(1 << FB));
      end
      vclip_q <= vclip_d;
      bk3_q   <= bk2_q;
      dc3_q   <= dc2_q;
    end
  end

  // stage d+3: halve, invert y, saturate
  function automatic logic signed [CW-1:0] sat(input logic signed [SMW+1:0] a);
    if (a > $signed((SMW+2)'(CMAX))) return CMAX;
    if (a < $signed({{(SMW+2-CW){1'b1}}, CMIN})) return CMIN;
    return a[CW-1:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 4; i++) begin
        sx_o[i] <= sat((SMW+2)'(sm_q[2*i] >>> 1));
        sy_o[i] <= sat($signed((SMW+2)'({1'b0, cfg_i.screen_height}) << FB)
                       - (SMW+2)'(sm_q[2*i+1] >>> 1));
      end
      clipped_o <= vclip_q | dc3_q;
      back_o    <= bk3_q;
    end
  end

  assign out_valid_o = vld_q[LAT-1];
endmodule

[sv/quad_cull_project_viewport_top.sv]
// ----------------------------------------------------------------------------
// quad_cull_project_viewport_top
// quad perspective projection, screen mapping and clip/back-face culling
// ----------------------------------------------------------------------------
// throughput: one quad per cycle; the depth is set by the one-bit-per-stage
// dividers for x/z and y/z; a stalled output freezes the whole pipeline
// reset: configuration registers return to their reset values, pipeline valids clear
module quad_cull_project_viewport_top #(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned FRAC_BITS   = 16
) (
  input logic clk_i,
  input logic rst_ni,
  qcpv_if.sink   in_if,
  qcpv_if.source out_if,
  qcpv_if.sink   cfg_if
);
  qcpv_pkg::cfg_t cfg;
  logic cfg_ready;

  qcpv_cfg u_cfg (
    .clk_i, .rst_ni,
    .cfg_valid_i(cfg_if.valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_if.data.index), .cfg_data_i(cfg_if.data.value),
    .cfg_o(cfg)
  );
  assign cfg_if.ready = cfg_ready;

  logic en, ov;
  logic signed [COORD_WIDTH-1:0] vx [4], vy [4], vz [4], sx [4], sy [4];
  logic clip, back;

  assign vx[0] = in_if.data.v0_x; assign vy[0] = in_if.data.v0_y;
  assign vz[0] = in_if.data.v0_z;
  assign vx[1] = in_if.data.v1_x; assign vy[1] = in_if.data.v1_y;
  assign vz[1] = in_if.data.v1_z;
  assign vx[2] = in_if.data.v2_x; assign vy[2] = in_if.data.v2_y;
  assign vz[2] = in_if.data.v2_z;
  assign vx[3] = in_if.data.v3_x; assign vy[3] = in_if.data.v3_y;
  assign vz[3] = in_if.data.v3_z;

  assign en = !ov || out_if.ready;
  assign in_if.ready = en;

  qcpv_core #(.CW(COORD_WIDTH), .FB(FRAC_BITS)) u_core (
    .clk_i, .rst_ni, .en_i(en), .in_valid_i(in_if.valid),
    .vx_i(vx), .vy_i(vy), .vz_i(vz), .cfg_i(cfg),
    .out_valid_o(ov), .sx_o(sx), .sy_o(sy), .clipped_o(clip), .back_o(back)
  );

  assign out_if.valid = ov;
  assign out_if.data.s0_x = sx[0]; assign out_if.data.s0_y = sy[0];
  assign out_if.data.s1_x = sx[1]; assign out_if.data.s1_y = sy[1];
  assign out_if.data.s2_x = sx[2]; assign out_if.data.s2_y = sy[2];
  assign out_if.data.s3_x = sx[3]; assign out_if.data.s3_y = sy[3];
  assign out_if.data.clipped = clip;
  assign out_if.data.back_facing = back;
endmodule

[verif/quad_cull_project_viewport_top_test.sv]
// ----------------------------------------------------------------------------
// quad_cull_project_viewport_top_test
// Self-checking bench for quad projection, screen mapping and culling. A
// clocked driver offers quads from a queue, and a clocked monitor checks each
// result beat against a bit-exact predictor. The run covers several register
// settings and several idle and stall patterns, including one long output
// hold-off.
// ----------------------------------------------------------------------------
module quad_cull_project_viewport_top_test;
  import qcpv_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [31:0] v0_x, v0_y, v0_z;
    logic signed [31:0] v1_x, v1_y, v1_z;
    logic signed [31:0] v2_x, v2_y, v2_z;
    logic signed [31:0] v3_x, v3_y, v3_z;
  } quad_t;

  typedef struct packed {
    logic signed [31:0] s0_x, s0_y, s1_x, s1_y, s2_x, s2_y, s3_x, s3_y;
    logic               clipped;
    logic               back_facing;
  } screen_t;

  typedef struct packed {
    reg_idx_e               index;
    logic [CFG_DATA_W-1:0]  value;
  } cfg_wr_t;

  localparam logic signed [31:0] CMAX = 32'sh7fffffff;
  localparam logic signed [31:0] CMIN = 32'sh80000000;
  localparam longint ONE = 64'd65536;
  localparam int LIMIT = 600000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  qcpv_if #(.payload_t(quad_t))   in_if ();
  qcpv_if #(.payload_t(screen_t)) out_if ();
  qcpv_if #(.payload_t(cfg_wr_t)) cfg_if ();

  quad_cull_project_viewport_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if.sink),
    .out_if (out_if.source),
    .cfg_if (cfg_if.sink)
  );

  cfg_t    view_cfg;
  quad_t   quad_queue[$];
  screen_t screen_expect[$];
  int      gap_pct = 0;
  int      stall_pct = 0;
  int      quads_in = 0;
  int      hold_left = 0;
  bit      hold_done = 0;
  int      errors = 0;
  int      cycles = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic signed [31:0] sat32(logic signed [127:0] v);
    if (v > 128'sh7fffffff) return CMAX;
    if (v < -128'sh80000000) return CMIN;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] project_coord(logic signed [31:0] c,
                                                       logic signed [31:0] z);
    logic signed [127:0] f, cc, zz, n;
    f = {97'd0, view_cfg.focal_distance};
    cc = c;
    zz = z;
    n = f * cc;
    if (zz == 0) return (n > 0) ? CMAX : ((n < 0) ? CMIN : 32'sd0);
    return sat32(n / zz);
  endfunction

  function automatic screen_t predict_quad(quad_t q);
    logic signed [31:0]  v[4][3];
    logic signed [31:0]  p[4][2];
    logic signed [255:0] e1[3], e2[3], nx, ny, nz, d;
    logic signed [127:0] w1, h1, hs, tx, ty;
    logic signed [63:0]  vw, vh, near_z, far_z;
    logic signed [31:0]  sc[8];
    bit                  depth_clip, view_clip, back, pos;
    int                  beyond;
    screen_t             r;
    v[0] = '{q.v0_x, q.v0_y, q.v0_z};
    v[1] = '{q.v1_x, q.v1_y, q.v1_z};
    v[2] = '{q.v2_x, q.v2_y, q.v2_z};
    v[3] = '{q.v3_x, q.v3_y, q.v3_z};
    near_z = view_cfg.near_plane;
    far_z = view_cfg.far_plane;
    depth_clip = 0;
    beyond = 0;
    for (int i = 0; i < 4; i++) begin
      if (v[i][2] <= near_z) depth_clip = 1;
      if (v[i][2] > far_z) beyond++;
    end
    if (beyond == 4) depth_clip = 1;
    for (int k = 0; k < 3; k++) begin
      e1[k] = 256'(v[1][k]) - 256'(v[0][k]);
      e2[k] = 256'(v[2][k]) - 256'(v[1][k]);
    end
    nx = e1[1] * e2[2] - e1[2] * e2[1];
    ny = e1[2] * e2[0] - e1[0] * e2[2];
    nz = e1[0] * e2[1] - e1[1] * e2[0];
    back = 0;
    if (view_cfg.cull_mode == CULL_CW || view_cfg.cull_mode == CULL_CCW) begin
      back = 1;
      for (int i = 0; i < 4; i++) begin
        d = nx * 256'(v[i][0]) + ny * 256'(v[i][1]) + nz * 256'(v[i][2]);
        pos = d > 0;
        if ((view_cfg.cull_mode == CULL_CW && pos) ||
            (view_cfg.cull_mode == CULL_CCW && !pos)) back = 0;
      end
    end
    for (int i = 0; i < 4; i++) begin
      p[i][0] = project_coord(v[i][0], v[i][2]);
      p[i][1] = project_coord(v[i][1], v[i][2]);
    end
    vw = {33'd0, view_cfg.view_width};
    vh = {33'd0, view_cfg.view_height};
    view_clip = 1;
    for (int i = 0; i < 3; i++) if (!(2 * 64'(p[i][1]) > vh)) view_clip = 0;
    begin
      bit c2, c3, c4;
      c2 = 1; c3 = 1; c4 = 1;
      for (int i = 0; i < 3; i++) begin
        if (!(2 * 64'(p[i][1]) < -vh)) c2 = 0;
        if (!(2 * 64'(p[i][0]) < -vw)) c3 = 0;
        if (!(2 * 64'(p[i][0]) > vw)) c4 = 0;
      end
      view_clip = view_clip | c2 | c3 | c4;
    end
    w1 = 128'(view_cfg.screen_width) - 1;
    h1 = 128'(view_cfg.screen_height) - 1;
    hs = 128'(view_cfg.screen_height) * ONE;
    for (int i = 0; i < 4; i++) begin
      tx = (w1 * (128'(ONE) + 128'(p[i][0]))) >>> 1;
      ty = (h1 * (128'(ONE) + 128'(p[i][1]))) >>> 1;
      sc[2 * i] = sat32(tx);
      sc[2 * i + 1] = sat32(hs - ty);
    end
    r.s0_x = sc[0]; r.s0_y = sc[1]; r.s1_x = sc[2]; r.s1_y = sc[3];
    r.s2_x = sc[4]; r.s2_y = sc[5]; r.s3_x = sc[6]; r.s3_y = sc[7];
    r.clipped = depth_clip | view_clip;
    r.back_facing = back;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v,
                                      logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t %s expected %h actual %h", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.data <= '0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        screen_expect.push_back(predict_quad(in_if.data));
        quads_in++;
      end
      if (in_if.valid && !in_if.ready) begin
      end else if (quad_queue.size() > 0 && $urandom_range(99) >= gap_pct) begin
        in_if.valid <= 1'b1;
        in_if.data <= quad_queue.pop_front();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // long output hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_done <= 1'b0;
      hold_left <= 0;
    end else if (!hold_done && quads_in >= 400) begin
      hold_done <= 1'b1;
      hold_left <= 300;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (screen_expect.size() == 0) begin
          $display("%0t unexpected result beat %h", $time, out_if.data);
          errors++;
        end else begin
          screen_t e;
          e = screen_expect.pop_front();
          check_field("s0_x", e.s0_x, out_if.data.s0_x);
          check_field("s0_y", e.s0_y, out_if.data.s0_y);
          check_field("s1_x", e.s1_x, out_if.data.s1_x);
          check_field("s1_y", e.s1_y, out_if.data.s1_y);
          check_field("s2_x", e.s2_x, out_if.data.s2_x);
          check_field("s2_y", e.s2_y, out_if.data.s2_y);
          check_field("s3_x", e.s3_x, out_if.data.s3_x);
          check_field("s3_y", e.s3_y, out_if.data.s3_y);
          check_field("clipped", 32'(e.clipped), 32'(out_if.data.clipped));
          check_field("back_facing", 32'(e.back_facing), 32'(out_if.data.back_facing));
        end
      end
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic write_reg(reg_idx_e idx, logic [31:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= '{index: idx, value: val};
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      REG_NEAR:   view_cfg.near_plane = val;
      REG_FAR:    view_cfg.far_plane = val;
      REG_FOCAL:  view_cfg.focal_distance = val[30:0];
      REG_VIEW_W: view_cfg.view_width = val[30:0];
      REG_VIEW_H: view_cfg.view_height = val[30:0];
      REG_SCR_W:  view_cfg.screen_width = val[12:0];
      REG_SCR_H:  view_cfg.screen_height = val[12:0];
      default:    view_cfg.cull_mode = cull_mode_e'(val[1:0]);
    endcase
  endtask

  task automatic load_config(cfg_t c);
    write_reg(REG_NEAR, c.near_plane);
    write_reg(REG_FAR, c.far_plane);
    write_reg(REG_FOCAL, {1'b0, c.focal_distance});
    write_reg(REG_VIEW_W, {1'b0, c.view_width});
    write_reg(REG_VIEW_H, {1'b0, c.view_height});
    write_reg(REG_SCR_W, {19'd0, c.screen_width});
    write_reg(REG_SCR_H, {19'd0, c.screen_height});
    write_reg(REG_CULL, {30'd0, c.cull_mode});
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain_pipeline();
    while (quad_queue.size() > 0 || in_if.valid || screen_expect.size() > 0)
      @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] pick_coord();
    case ($urandom_range(9))
      0:       return CMAX;
      1:       return CMIN;
      2:       return 32'sd0;
      3, 4:    return $urandom;
      default: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
    endcase
  endfunction

  function automatic logic signed [31:0] pick_depth();
    case ($urandom_range(9))
      0:       return $urandom;
      1:       return $signed($urandom_range(0, 32'h0002_0000));
      2:       return -$signed($urandom_range(0, 32'h0002_0000));
      3:       return 32'sd0;
      4:       return CMAX;
      default: return $signed($urandom_range(32'h0001_0000, 32'h0100_0000));
    endcase
  endfunction

  function automatic quad_t random_quad();
    quad_t q;
    if ($urandom_range(9) < 2) begin
      q = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    end else begin
      q.v0_x = pick_coord(); q.v0_y = pick_coord(); q.v0_z = pick_depth();
      q.v1_x = pick_coord(); q.v1_y = pick_coord(); q.v1_z = pick_depth();
      q.v2_x = pick_coord(); q.v2_y = pick_coord(); q.v2_z = pick_depth();
      q.v3_x = pick_coord(); q.v3_y = pick_coord(); q.v3_z = pick_depth();
    end
    return q;
  endfunction

  function automatic cfg_t random_config(int sel);
    cfg_t c;
    c.near_plane = (sel % 4 == 0) ? CMIN : $signed($urandom_range(0, 32'h0002_0000));
    c.far_plane = (sel % 4 == 1) ? CMAX : $signed($urandom_range(32'h0004_0000, 32'h0200_0000));
    c.focal_distance = (sel % 5 == 0) ? 31'd0 :
                       (sel % 5 == 1) ? 31'h7fffffff : 31'($urandom_range(1, 32'h0004_0000));
    c.view_width = (sel % 3 == 0) ? 31'd0 :
                   (sel % 3 == 1) ? 31'h7fffffff : 31'($urandom_range(1, 32'h0008_0000));
    c.view_height = (sel % 3 == 1) ? 31'd0 :
                    (sel % 3 == 2) ? 31'h7fffffff : 31'($urandom_range(1, 32'h0008_0000));
    c.screen_width = (sel % 2 == 0) ? 13'd1 : 13'd4096;
    c.screen_height = (sel % 2 == 0) ? 13'd4096 : 13'($urandom_range(1, 4096));
    c.cull_mode = cull_mode_e'(sel % 4);
    return c;
  endfunction

  initial begin
    cfg_t  c;
    quad_t q;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    view_cfg = '{near_plane: 32'sd65536, far_plane: 32'sd65536000,
                 focal_distance: 31'd65536, view_width: 31'd131072,
                 view_height: 31'd131072, screen_width: 13'd480,
                 screen_height: 13'd480, cull_mode: CULL_CCW};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed quads, then random ones, at reset settings
    quad_queue.push_back({12{32'sh7fffffff}});
    quad_queue.push_back({12{32'sh80000000}});
    quad_queue.push_back('0);
    // square at depth 2, back-facing under the reset cull mode
    quad_queue.push_back({-32'sd65536, -32'sd65536, 32'sd131072,
                          32'sd65536, -32'sd65536, 32'sd131072,
                          32'sd65536, 32'sd65536, 32'sd131072,
                          -32'sd65536, 32'sd65536, 32'sd131072});
    // same square wound the other way
    quad_queue.push_back({-32'sd65536, 32'sd65536, 32'sd131072,
                          32'sd65536, 32'sd65536, 32'sd131072,
                          32'sd65536, -32'sd65536, 32'sd131072,
                          -32'sd65536, -32'sd65536, 32'sd131072});
    // zero depth with positive, negative and zero products
    quad_queue.push_back({32'sd5, -32'sd5, 32'sd0, -32'sd7, 32'sd0, 32'sd0,
                          32'sd0, 32'sd9, 32'sd0, 32'sd1, 32'sd1, 32'sd0});
    // overflowing projection from tiny depth
    quad_queue.push_back({32'sh7fff0000, 32'sh80000000, 32'sd1,
                          32'sh40000000, 32'sh40000000, 32'sd1,
                          -32'sh40000000, 32'sd3, -32'sd1,
                          32'sd0, 32'sd0, 32'sd70000});
    // all beyond far plane
    quad_queue.push_back({32'sd0, 32'sd0, 32'sd70000000, 32'sd1, 32'sd0, 32'sd70000000,
                          32'sd0, 32'sd1, 32'sd70000000, 32'sd1, 32'sd1, 32'sd70000000});
    // all right of the view plane, all above, all below, all left
    quad_queue.push_back({32'sd400000, 32'sd0, 32'sd131072, 32'sd500000, 32'sd1, 32'sd131072,
                          32'sd600000, 32'sd2, 32'sd131072, 32'sd0, 32'sd0, 32'sd131072});
    quad_queue.push_back({32'sd0, 32'sd400000, 32'sd131072, 32'sd1, 32'sd500000, 32'sd131072,
                          32'sd2, 32'sd600000, 32'sd131072, 32'sd0, 32'sd0, 32'sd131072});
    quad_queue.push_back({32'sd0, -32'sd400000, 32'sd131072, 32'sd1, -32'sd500000, 32'sd131072,
                          32'sd2, -32'sd600000, 32'sd131072, 32'sd0, 32'sd0, 32'sd131072});
    quad_queue.push_back({-32'sd400000, 32'sd0, 32'sd131072, -32'sd500000, 32'sd1, 32'sd131072,
                          -32'sd600000, 32'sd2, 32'sd131072, 32'sd0, 32'sd0, 32'sd131072});
    // vertex exactly on the near plane
    quad_queue.push_back({32'sd0, 32'sd0, 32'sd65536, 32'sd1, 32'sd0, 32'sd131072,
                          32'sd0, 32'sd1, 32'sd131072, 32'sd1, 32'sd1, 32'sd131072});
    repeat (5) quad_queue.push_back(random_quad());
    drain_pipeline();

    // random quads and a zero quad at extreme settings, each cull mode
    for (int m = 0; m < 4; m++) begin
      c = random_config(m);
      load_config(c);
      for (int k = 0; k < 3; k++) quad_queue.push_back(random_quad());
      quad_queue.push_back('0);
      drain_pipeline();
    end

    for (int ph = 0; ph < 8; ph++) begin
      c = random_config(ph + 3);
      load_config(c);
      case (ph % 4)
        0: begin gap_pct = 0; stall_pct = 0; end
        1: begin gap_pct = 59; stall_pct = 0; end
        2: begin gap_pct = 0; stall_pct = 59; end
        default: begin gap_pct = 20; stall_pct = 20; end
      endcase
      for (int k = 0; k < 240; k++) begin
        q = random_quad();
        quad_queue.push_back(q);
      end
      drain_pipeline();
      gap_pct = 0;
      stall_pct = 0;
    end

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
